[src/assert_macros.svh]
// Assertion macros used by the top-level RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/hcg_pkg.sv]
package hcg_pkg;

   // Fixed field widths of the request and response items.
   localparam int OFFSET_W   = 31;
   localparam int RADIX_IN_W = 8;
   localparam int COORD_W    = 32;
   localparam int START_W    = 31;
   localparam int FRAC_W     = 32;
   localparam int PROD_W     = 2 * FRAC_W;

   // Request tdata layout, lowest bit first.
   localparam int OFF_LSB    = 0;
   localparam int RADIX_LSB  = OFF_LSB + OFFSET_W;
   localparam int MIN_LSB    = RADIX_LSB + RADIX_IN_W;
   localparam int MAX_LSB    = MIN_LSB + COORD_W;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 32;

   // Start number after reset.
   localparam logic [START_W-1:0] START_RESET = START_W'(1);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic digit_end;
      logic frac_step;
      logic mul;
      logic out_load;
   } hcg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic seq_zero;
      logic base_bad;
      logic out_busy;
   } hcg_status_type;

endpackage

[src/halton_coordinate_generator.sv]
// Halton coordinate generator. Each request item gives a point offset, a base and a signed
// Q16.16 range; the block adds the offset to the start number register, reverses the base-b
// digits of that sequence number into a truncated Q0.32 radical inverse, and returns the range
// minimum plus the floored, scaled fraction of the span. One item is in work at a time. Each
// base digit is found by a one-bit-per-cycle restoring divider over SEQ_WIDTH bits, the
// fraction by a 32-step long division, then come a multiply state and an output state. A
// sequence number of zero or a base below two skips the digit and fraction steps and goes
// straight to the multiply. The output state waits while an earlier result is still held and
// not taken. The result waits in an output register, so the next item is taken while an
// earlier result is still pending.
module halton_coordinate_generator import hcg_pkg::*; #(
   parameter int SEQ_WIDTH   = 32,
   parameter int RADIX_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Start number register write.
   input  logic                  csr_wr_en,
   input  logic [START_W-1:0]    csr_wr_data,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // point_offset, radix, range_min, range_max, zero pad
   input  logic                  req_tlast,
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // coordinate
   output logic                  rsp_tlast
);

`include "assert_macros.svh"

   // The base field is eight bits wide; narrower bases keep the low bits.
   localparam int BASE_W = (RADIX_WIDTH < RADIX_IN_W) ? RADIX_WIDTH : RADIX_IN_W;

   hcg_cmd_type    cmd;
   hcg_status_type status;

   hcg_ctrl #(
      .SEQ_WIDTH (SEQ_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hcg_datapath #(
      .SEQ_WIDTH (SEQ_WIDTH),
      .BASE_W    (BASE_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   // A new result never overwrites one that is still waiting.
   `ASSERT_SAME(a_no_overwrite, clock, reset, cmd.out_load, !rsp_tvalid || rsp_tready)
   // After an item is accepted the block is busy with it.
   `ASSERT_NEXT(a_one_in_work, clock, reset, req_tvalid && req_tready, !req_tready)
   // The radix divider runs only on a usable base.
   `ASSERT_SAME(a_div_base_ok, clock, reset, cmd.div_step, !status.base_bad)
   // A load happens only on an accepted item.
   `ASSERT_SAME(a_load_on_accept, clock, reset, cmd.load, req_tvalid && req_tready)

endmodule

[src/hcg_ctrl.sv]
module hcg_ctrl import hcg_pkg::*; #(
   parameter int SEQ_WIDTH = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  hcg_status_type status,
   output hcg_cmd_type    cmd
);

   localparam int CNT_W = $clog2(SEQ_WIDTH > FRAC_W ? SEQ_WIDTH : FRAC_W);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_DIGIT  = 3'd2;
   localparam logic [2:0] S_DIGEND = 3'd3;
   localparam logic [2:0] S_FRAC   = 3'd4;
   localparam logic [2:0] S_MUL    = 3'd5;
   localparam logic [2:0] S_FIN    = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Only one item is in work at a time.
   assign req_tready = (state_ff == S_IDLE);

   // Sequencer over digit extraction, fraction division and scaling.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cnt_in = '0;
            if (status.base_bad || status.seq_zero) begin
               state_in = S_MUL;
            end else begin
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(SEQ_WIDTH - 1)) begin
               state_in = S_DIGEND;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_DIGEND: begin
            cmd.digit_end = 1'b1;
            cnt_in        = '0;
            if (status.seq_zero) begin
               state_in = S_FRAC;
            end else begin
               state_in = S_DIGIT;
            end
         end
         S_FRAC: begin
            cmd.frac_step = 1'b1;
            if (cnt_ff == CNT_W'(FRAC_W - 1)) begin
               state_in = S_MUL;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[src/hcg_datapath.sv]
module hcg_datapath import hcg_pkg::*; #(
   parameter int SEQ_WIDTH = 32,
   parameter int BASE_W    = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hcg_cmd_type           cmd,
   output hcg_status_type        status,
   input  logic                  csr_wr_en,
   input  logic [START_W-1:0]    csr_wr_data,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int DEN_W = SEQ_WIDTH + BASE_W;

   logic [START_W-1:0]    start_ff;
   logic [SEQ_WIDTH-1:0]  q_ff, q_in;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [BASE_W-1:0]     drem_ff, drem_in;
   logic [DEN_W-1:0]      rev_ff, rev_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [DEN_W-1:0]      frem_ff, frem_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic [COORD_W-1:0]    mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [COORD_W-1:0]    lo_ff, lo_in;
   logic                  last_ff, last_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [31:0]               seq_sum;
   logic [COORD_W-1:0]        req_min, req_max;
   logic [COORD_W:0]          span, span_abs;
   logic [BASE_W:0]           div_trial;
   logic                      div_ge;
   logic [DEN_W+BASE_W-1:0]   rev_prod, den_prod;
   logic [DEN_W:0]            frac_trial;
   logic                      frac_ge;
   logic [COORD_W:0]          quot;
   logic [COORD_W-1:0]        coord;

   // Request fields and the sequence number.
   assign req_min = req_tdata[MIN_LSB +: COORD_W];
   assign req_max = req_tdata[MAX_LSB +: COORD_W];
   assign seq_sum = 32'(start_ff) + 32'(req_tdata[OFF_LSB +: OFFSET_W]);

   // Signed span of the output range and its magnitude.
   assign span     = {req_max[COORD_W-1], req_max} - {req_min[COORD_W-1], req_min};
   assign span_abs = span[COORD_W] ? ((COORD_W+1)'(0) - span) : span;

   // One restoring step of the division by the radix, quotient shifted into q.
   assign div_trial = {drem_ff, q_ff[SEQ_WIDTH-1]};
   assign div_ge    = (div_trial >= {1'b0, base_ff});

   // Digit accumulation: append the digit to the reversed number, grow the denominator.
   assign rev_prod = rev_ff * base_ff;
   assign den_prod = den_ff * base_ff;

   // One step of the long division rev * 2^32 / den.
   assign frac_trial = {frem_ff, 1'b0};
   assign frac_ge    = (frac_trial >= {1'b0, den_ff});

   // Scaled offset, rounded toward minus infinity for a reversed range.
   assign quot  = (COORD_W+1)'(prod_ff[PROD_W-1:FRAC_W])
                + (COORD_W+1)'(neg_ff && (prod_ff[FRAC_W-1:0] != '0));
   assign coord = neg_ff ? (lo_ff - quot[COORD_W-1:0]) : (lo_ff + quot[COORD_W-1:0]);

   // Next values of the working registers.
   always_comb begin
      q_in         = q_ff;
      base_in      = base_ff;
      drem_in      = drem_ff;
      rev_in       = rev_ff;
      den_in       = den_ff;
      frem_in      = frem_ff;
      frac_in      = frac_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      lo_in        = lo_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         q_in    = SEQ_WIDTH'(seq_sum);
         base_in = BASE_W'(req_tdata[RADIX_LSB +: RADIX_IN_W]);
         drem_in = '0;
         rev_in  = '0;
         den_in  = DEN_W'(1);
         frem_in = '0;
         frac_in = '0;
         mag_in  = span_abs[COORD_W-1:0];
         neg_in  = span[COORD_W];
         lo_in   = req_min;
         last_in = req_tlast;
      end
      if (cmd.div_step) begin
         q_in    = {q_ff[SEQ_WIDTH-2:0], div_ge};
         drem_in = div_ge ? BASE_W'(div_trial - {1'b0, base_ff}) : div_trial[BASE_W-1:0];
      end
      if (cmd.digit_end) begin
         rev_in  = DEN_W'(rev_prod) + DEN_W'(drem_ff);
         den_in  = DEN_W'(den_prod);
         frem_in = DEN_W'(rev_prod) + DEN_W'(drem_ff);
         drem_in = '0;
      end
      if (cmd.frac_step) begin
         frem_in = frac_ge ? DEN_W'(frac_trial - {1'b0, den_ff}) : frac_trial[DEN_W-1:0];
         frac_in = {frac_ff[FRAC_W-2:0], frac_ge};
      end
      if (cmd.mul) begin
         prod_in = PROD_W'(frac_ff) * PROD_W'(mag_ff);
      end
      // Output register: a loaded item waits here until taken.
      if (cmd.out_load) begin
         rsp_data_in  = coord;
         rsp_last_in  = last_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      base_ff     <= base_in;
      drem_ff     <= drem_in;
      rev_ff      <= rev_in;
      den_ff      <= den_in;
      frem_ff     <= frem_in;
      frac_ff     <= frac_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      lo_ff       <= lo_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Control registers: start number and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= START_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            start_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.seq_zero = (q_ff == '0);
   assign status.base_bad = (base_ff < BASE_W'(2));
   assign status.out_busy = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
